// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// invariant checked at every rising clock edge
`define SRRW_ASSERT(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) \
		else $error(msg);

// same-cycle implication
`define SRRW_ASSERT_IMP(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication
`define SRRW_ASSERT_NXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

// File: rtl/srrw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_pkg
// shared widths, result kinds, opcodes and the slot memory entry type
// ----------------------------------------------------------------------------
package srrw_pkg;

	localparam int DEF_WINDOW_SLOTS  = 16;
	localparam int DEF_SEGMENT_BYTES = 1000;

	localparam int SIZE_W   = 24;
	localparam int HANDLE_W = 32;
	localparam int LEN_W    = 10;
	localparam int KIND_W   = 3;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_DELIVER   = 3'd0;
	localparam kind_t KIND_REQUEST   = 3'd1;
	localparam kind_t KIND_STORED    = 3'd2;
	localparam kind_t KIND_OLD       = 3'd3;
	localparam kind_t KIND_DUP       = 3'd4;
	localparam kind_t KIND_FOREIGN   = 3'd5;
	localparam kind_t KIND_NONE_MISS = 3'd6;
	localparam kind_t KIND_BEYOND    = 3'd7;

	localparam logic OP_ARRIVE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef struct packed {
		logic                received;
		logic [HANDLE_W-1:0] handle;
	} slot_entry_t;

endpackage

// File: rtl/srrw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_if
// valid/ready channels: size config, segment arrivals and results
// ----------------------------------------------------------------------------
interface srrw_cfg_if;
	import srrw_pkg::*;
	logic              valid;
	logic              ready;
	logic [SIZE_W-1:0] total_size;
	modport source (output valid, output total_size, input ready);
	modport sink (input valid, input total_size, output ready);
endinterface

interface srrw_arr_if;
	import srrw_pkg::*;
	logic                valid;
	logic                ready;
	logic                op;
	logic                from_server;
	logic [SIZE_W-1:0]   start_offset;
	logic [HANDLE_W-1:0] payload_handle;
	modport source (output valid, output op, output from_server, output start_offset,
		output payload_handle, input ready);
	modport sink (input valid, input op, input from_server, input start_offset,
		input payload_handle, output ready);
endinterface

interface srrw_res_if;
	import srrw_pkg::*;
	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [SIZE_W-1:0]   byte_offset;
	logic [LEN_W-1:0]    length;
	logic [HANDLE_W-1:0] handle_out;
	logic                last;
	logic                done_res;
	modport source (output valid, output kind, output byte_offset, output length,
		output handle_out, output last, output done_res, input ready);
	modport sink (input valid, input kind, input byte_offset, input length,
		input handle_out, input last, input done_res, output ready);
endinterface

// File: rtl/selective_repeat_receive_window.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// selective_repeat_receive_window
// receive window of a segmented download: drops bad arrivals, stores held
// segment handles in a ring, delivers the in-order run and requests gaps
// ----------------------------------------------------------------------------
// One item is in work at a time and results leave through a one-deep output
// register, so the next item is taken while the last result still waits.
// Every window step passes through a read state and a read-data state because
// the ring store has a registered read. An arrival dropped at the checks goes
// through check and a single result; a duplicate adds the slot lookup. A
// stored arrival passes check and lookup, probes the run of held segments
// from the window base until a missing slot, the window or the file end ends
// it, then emits one delivery per segment of that run and returns to idle, or
// gives a single stored result when nothing is delivered. A timeout tick
// probes every slot of the window span to count the missing ones, then walks
// up to the last missing one with a request for each, or gives a single
// result when nothing is missing. A stalled result side adds its stall to each
// result. A size write makes the block busy for one cycle while the segment
// count is formed. After reset a clearing pass writes every slot before the
// first item is taken.
module selective_repeat_receive_window #(
	parameter int WINDOW_SLOTS  = srrw_pkg::DEF_WINDOW_SLOTS,
	parameter int SEGMENT_BYTES = srrw_pkg::DEF_SEGMENT_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	srrw_cfg_if.sink    cfg,
	srrw_arr_if.sink    arrival,
	srrw_res_if.source  result
);
	import srrw_pkg::*;

	localparam int SEG_W  = $clog2(((2 ** SIZE_W) - 1 + SEGMENT_BYTES - 1)
		/ SEGMENT_BYTES + 1);
	localparam int SLOT_W = $clog2(WINDOW_SLOTS);

	logic [SIZE_W-1:0] total_size;
	logic [SEG_W-1:0]  count;
	logic              size_busy;
	logic              mem_re;
	logic [SLOT_W-1:0] mem_raddr;
	slot_entry_t       mem_rdata;
	logic              mem_we;
	logic [SLOT_W-1:0] mem_waddr;
	slot_entry_t       mem_wdata;

	srrw_size #(
		.SEGMENT_BYTES (SEGMENT_BYTES)
	) u_size (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg),
		.total_size (total_size),
		.count      (count),
		.busy       (size_busy)
	);

	srrw_slot_mem #(
		.DEPTH (WINDOW_SLOTS)
	) u_mem (
		.clk   (clk),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata)
	);

	srrw_ctrl #(
		.WINDOW_SLOTS  (WINDOW_SLOTS),
		.SEGMENT_BYTES (SEGMENT_BYTES)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.arrival    (arrival),
		.result     (result),
		.total_size (total_size),
		.count      (count),
		.size_busy  (size_busy),
		.mem_re     (mem_re),
		.mem_raddr  (mem_raddr),
		.mem_rdata  (mem_rdata),
		.mem_we     (mem_we),
		.mem_waddr  (mem_waddr),
		.mem_wdata  (mem_wdata)
	);

endmodule

// File: rtl/srrw_slot_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_slot_mem
// ring slot store, one write and one registered read port
// ----------------------------------------------------------------------------
module srrw_slot_mem #(
	parameter int DEPTH = srrw_pkg::DEF_WINDOW_SLOTS
) (
	input  logic                       clk,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output srrw_pkg::slot_entry_t      rdata,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  srrw_pkg::slot_entry_t      wdata
);
	import srrw_pkg::*;

	slot_entry_t mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: rtl/srrw_size.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srrw_size
// file size register and segment count, ceil(size / segment bytes)
// ----------------------------------------------------------------------------
module srrw_size #(
	parameter int SEGMENT_BYTES = srrw_pkg::DEF_SEGMENT_BYTES,
	localparam int SEG_W = $clog2(((2 ** srrw_pkg::SIZE_W) - 1 + SEGMENT_BYTES - 1)
		/ SEGMENT_BYTES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	srrw_cfg_if.sink                    cfg,
	output logic [srrw_pkg::SIZE_W-1:0] total_size,
	output logic [SEG_W-1:0]            count,
	output logic                        busy
);
	import srrw_pkg::*;

	localparam int X_W     = SIZE_W + 1;
	localparam int CNT_SH  = X_W + $clog2(SEGMENT_BYTES);
	localparam int CMUL_W  = SIZE_W + 3;
	localparam logic [CMUL_W-1:0] CNT_MUL = CMUL_W'(((64'd1 << CNT_SH)
		+ 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES));
	localparam int CPROD_W = CNT_SH + SEG_W + 1;

	logic [SIZE_W-1:0]  total_q;
	logic [SEG_W-1:0]   count_q;
	logic               busy_q;
	logic [X_W-1:0]     round_up;
	logic [CPROD_W-1:0] cprod;

	assign cfg.ready  = !busy_q;
	assign total_size = total_q;
	assign count      = count_q;
	assign busy       = busy_q;

	// reciprocal multiply, exact over the full size range
	assign round_up = X_W'(total_q) + X_W'(SEGMENT_BYTES - 1);
	assign cprod    = CPROD_W'(round_up) * CPROD_W'(CNT_MUL);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
			busy_q  <= 1'b0;
		end else begin
			busy_q <= cfg.valid && !busy_q;
			if (cfg.valid && !busy_q) begin
				total_q <= cfg.total_size;
			end
			if (busy_q) begin
				count_q <= cprod[CNT_SH +: SEG_W];
			end
		end
	end

endmodule

// File: rtl/srrw_ctrl.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// srrw_ctrl
// item sequencer: arrival checks, slot read-modify-write, two-pass window
// scans (count then emit) and the result register
// ----------------------------------------------------------------------------
module srrw_ctrl #(
	parameter int WINDOW_SLOTS  = srrw_pkg::DEF_WINDOW_SLOTS,
	parameter int SEGMENT_BYTES = srrw_pkg::DEF_SEGMENT_BYTES,
	localparam int SEG_W = $clog2(((2 ** srrw_pkg::SIZE_W) - 1 + SEGMENT_BYTES - 1)
		/ SEGMENT_BYTES + 1),
	localparam int SLOT_W = $clog2(WINDOW_SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	srrw_arr_if.sink                    arrival,
	srrw_res_if.source                  result,
	input  logic [srrw_pkg::SIZE_W-1:0] total_size,
	input  logic [SEG_W-1:0]            count,
	input  logic                        size_busy,
	output logic                        mem_re,
	output logic [SLOT_W-1:0]           mem_raddr,
	input  srrw_pkg::slot_entry_t       mem_rdata,
	output logic                        mem_we,
	output logic [SLOT_W-1:0]           mem_waddr,
	output srrw_pkg::slot_entry_t       mem_wdata
);
	import srrw_pkg::*;

	localparam int CNT_W   = $clog2(WINDOW_SLOTS + 1);
	localparam int WB      = ((SEG_W > CNT_W) ? SEG_W : CNT_W) + 1;
	localparam int OFF_SH  = SIZE_W + $clog2(SEGMENT_BYTES);
	localparam int MUL_W   = SIZE_W + 2;
	localparam logic [MUL_W-1:0] OFF_MUL = MUL_W'(((64'd1 << OFF_SH)
		+ 64'(SEGMENT_BYTES) - 64'd1) / 64'(SEGMENT_BYTES));
	localparam int PROD_W  = OFF_SH + SEG_W + 1;
	localparam int D_W     = $clog2(SEGMENT_BYTES + 1);
	localparam int OFF_W   = SEG_W + D_W;
	localparam int CMP_W   = (OFF_W > SIZE_W) ? OFF_W : SIZE_W;

	localparam logic [3:0] ST_CLEAR    = 4'd0;
	localparam logic [3:0] ST_IDLE     = 4'd1;
	localparam logic [3:0] ST_CHECK    = 4'd2;
	localparam logic [3:0] ST_LOOKUP   = 4'd3;
	localparam logic [3:0] ST_PROBE    = 4'd4;
	localparam logic [3:0] ST_PROBE_RD = 4'd5;
	localparam logic [3:0] ST_EMIT     = 4'd6;
	localparam logic [3:0] ST_EMIT_RD  = 4'd7;
	localparam logic [3:0] ST_SINGLE   = 4'd8;

	logic [3:0]          state_q;
	logic [SLOT_W-1:0]   clr_q;
	logic [SEG_W-1:0]    base_q;
	logic [SLOT_W-1:0]   bslot_q;
	logic [CNT_W-1:0]    g_q;
	logic [SLOT_W-1:0]   sslot_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [CNT_W-1:0]    emit_q;
	logic                op_s1;
	kind_t               kind_q;
	logic                done_q;

	logic                from_s1;
	logic [SEG_W-1:0]    seg_s1;
	logic [HANDLE_W-1:0] handle_s1;
	logic [SLOT_W-1:0]   aslot_q;
	logic [OFF_W-1:0]    off_s1;

	logic                res_valid_q;
	kind_t               res_kind_q;
	logic [SIZE_W-1:0]   res_off_q;
	logic [LEN_W-1:0]    res_len_q;
	logic [HANDLE_W-1:0] res_handle_q;
	logic                res_last_q;
	logic                res_done_q;

	logic                accept;
	logic                out_free;
	logic                is_tick;
	logic                rec;
	logic [PROD_W-1:0]   seg_prod;
	logic [SEG_W-1:0]    seg_c;
	logic [SEG_W-1:0]    seg_diff;
	logic                is_old;
	logic                is_beyond;
	logic                fresh;
	logic [SLOT_W:0]     slot_sum;
	logic [SLOT_W-1:0]   aslot_c;
	logic [SLOT_W-1:0]   sslot_inc;
	logic [SLOT_W-1:0]   bslot_inc;
	logic                in_span;
	logic [SEG_W-1:0]    scan_seg;
	logic                base_done;
	logic                run_done;
	logic [CMP_W-1:0]    off_x;
	logic [CMP_W-1:0]    total_x;
	logic [CMP_W-1:0]    rest;
	logic [LEN_W-1:0]    len_c;
	logic                last_c;
	logic                single_go;
	logic                emit_go;

	assign accept        = arrival.valid && arrival.ready;
	assign arrival.ready = (state_q == ST_IDLE) && !size_busy;
	assign out_free      = !res_valid_q || result.ready;
	assign is_tick       = (op_s1 == OP_TICK);
	assign rec           = mem_rdata.received;

	// segment index of the arriving offset, reciprocal multiply
	assign seg_prod = PROD_W'(arrival.start_offset) * PROD_W'(OFF_MUL);
	assign seg_c    = seg_prod[OFF_SH +: SEG_W];

	assign seg_diff  = seg_s1 - base_q;
	assign is_old    = seg_s1 < base_q;
	assign is_beyond = (WB'(seg_diff) >= WB'(WINDOW_SLOTS)) || (seg_s1 >= count);
	assign fresh     = from_s1 && !is_old && !is_beyond;

	// ring slot of the arrival, offset from the base slot is below the depth
	assign slot_sum = (SLOT_W + 1)'(bslot_q) + (SLOT_W + 1)'(seg_diff);
	assign aslot_c  = (slot_sum >= (SLOT_W + 1)'(WINDOW_SLOTS))
		? SLOT_W'(slot_sum - (SLOT_W + 1)'(WINDOW_SLOTS)) : SLOT_W'(slot_sum);

	assign sslot_inc = (sslot_q == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : sslot_q + 1'b1;
	assign bslot_inc = (bslot_q == SLOT_W'(WINDOW_SLOTS - 1)) ? '0 : bslot_q + 1'b1;

	assign in_span   = (g_q < CNT_W'(WINDOW_SLOTS))
		&& ((WB'(base_q) + WB'(g_q)) < WB'(count));
	assign scan_seg  = base_q + SEG_W'(g_q);
	assign base_done = base_q >= count;
	assign run_done  = (WB'(base_q) + WB'(cnt_q)) >= WB'(count);

	// segment length clipped at end of file
	assign off_x   = CMP_W'(off_s1);
	assign total_x = CMP_W'(total_size);
	assign rest    = (off_x < total_x) ? total_x - off_x : '0;
	assign len_c   = (rest < CMP_W'(SEGMENT_BYTES)) ? LEN_W'(rest) : LEN_W'(SEGMENT_BYTES);
	assign last_c  = (CNT_W'(emit_q + 1'b1) == cnt_q);

	assign single_go = (state_q == ST_SINGLE) && out_free;
	assign emit_go   = (state_q == ST_EMIT_RD) && out_free && (!is_tick || !rec);

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = sslot_q;
		mem_we    = 1'b0;
		mem_waddr = sslot_q;
		mem_wdata = '{received: 1'b0, handle: '0};
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
			end
			ST_CHECK: begin
				mem_re    = fresh;
				mem_raddr = aslot_c;
			end
			ST_LOOKUP: begin
				mem_we    = !rec;
				mem_waddr = aslot_q;
				mem_wdata = '{received: 1'b1, handle: handle_s1};
			end
			ST_PROBE: begin
				mem_re = in_span;
			end
			ST_EMIT: begin
				mem_re = 1'b1;
			end
			ST_EMIT_RD: begin
				mem_we = emit_go && !is_tick;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			base_q  <= '0;
			bslot_q <= '0;
			g_q     <= '0;
			sslot_q <= '0;
			cnt_q   <= '0;
			emit_q  <= '0;
			op_s1   <= OP_ARRIVE;
			kind_q  <= KIND_STORED;
			done_q  <= 1'b0;
		end else begin
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == SLOT_W'(WINDOW_SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end else begin
						clr_q <= clr_q + 1'b1;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						op_s1   <= arrival.op;
						g_q     <= '0;
						sslot_q <= bslot_q;
						cnt_q   <= '0;
						state_q <= (arrival.op == OP_TICK) ? ST_PROBE : ST_CHECK;
					end
				end
				ST_CHECK: begin
					done_q <= base_done;
					if (!from_s1) begin
						kind_q  <= KIND_FOREIGN;
						state_q <= ST_SINGLE;
					end else if (is_old) begin
						kind_q  <= KIND_OLD;
						state_q <= ST_SINGLE;
					end else if (is_beyond) begin
						kind_q  <= KIND_BEYOND;
						state_q <= ST_SINGLE;
					end else begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					if (rec) begin
						kind_q  <= KIND_DUP;
						done_q  <= base_done;
						state_q <= ST_SINGLE;
					end else begin
						state_q <= ST_PROBE;
					end
				end
				ST_PROBE: begin
					if (in_span) begin
						state_q <= ST_PROBE_RD;
					end else if (cnt_q == '0) begin
						kind_q  <= is_tick ? KIND_NONE_MISS : KIND_STORED;
						done_q  <= base_done;
						state_q <= ST_SINGLE;
					end else begin
						g_q     <= '0;
						sslot_q <= bslot_q;
						emit_q  <= '0;
						done_q  <= is_tick ? base_done : run_done;
						state_q <= ST_EMIT;
					end
				end
				ST_PROBE_RD: begin
					// tick counts gaps, arrival counts the held run from the base
					if (is_tick || rec) begin
						if (is_tick != rec) begin
							cnt_q <= cnt_q + 1'b1;
						end
						g_q     <= g_q + 1'b1;
						sslot_q <= sslot_inc;
					end else begin
						g_q <= CNT_W'(WINDOW_SLOTS);
					end
					state_q <= ST_PROBE;
				end
				ST_EMIT: begin
					state_q <= ST_EMIT_RD;
				end
				ST_EMIT_RD: begin
					if (is_tick && rec) begin
						g_q     <= g_q + 1'b1;
						sslot_q <= sslot_inc;
						state_q <= ST_EMIT;
					end else if (out_free) begin
						emit_q  <= emit_q + 1'b1;
						sslot_q <= sslot_inc;
						if (is_tick) begin
							g_q <= g_q + 1'b1;
						end else begin
							base_q  <= base_q + 1'b1;
							bslot_q <= bslot_inc;
						end
						state_q <= last_c ? ST_IDLE : ST_EMIT;
					end
				end
				ST_SINGLE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			from_s1   <= arrival.from_server;
			seg_s1    <= seg_c;
			handle_s1 <= arrival.payload_handle;
		end
		if (state_q == ST_CHECK) begin
			aslot_q <= aslot_c;
		end
		if (state_q == ST_EMIT) begin
			off_s1 <= OFF_W'(scan_seg) * OFF_W'(SEGMENT_BYTES);
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (single_go || emit_go) begin
			res_valid_q <= 1'b1;
		end else if (result.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (single_go) begin
			res_kind_q   <= kind_q;
			res_off_q    <= '0;
			res_len_q    <= '0;
			res_handle_q <= '0;
			res_last_q   <= 1'b1;
			res_done_q   <= done_q;
		end else if (emit_go) begin
			res_kind_q   <= is_tick ? KIND_REQUEST : KIND_DELIVER;
			res_off_q    <= off_x[SIZE_W-1:0];
			res_len_q    <= len_c;
			res_handle_q <= is_tick ? '0 : mem_rdata.handle;
			res_last_q   <= last_c;
			res_done_q   <= done_q;
		end
	end

	assign result.valid       = res_valid_q;
	assign result.kind        = res_kind_q;
	assign result.byte_offset = res_off_q;
	assign result.length      = res_len_q;
	assign result.handle_out  = res_handle_q;
	assign result.last        = res_last_q;
	assign result.done_res    = res_done_q;

	`SRRW_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(WINDOW_SLOTS), "result count beyond window")
	`SRRW_ASSERT_IMP(a_emit_bound, state_q == ST_EMIT_RD, emit_q < cnt_q, "emit overran count")
	`SRRW_ASSERT_IMP(a_run_held, (state_q == ST_EMIT_RD) && !is_tick, rec, "run slot not held")
	`SRRW_ASSERT_NXT(a_last_ends, single_go || (emit_go && last_c), state_q == ST_IDLE, "item not closed")

endmodule
